/* design/hkre_pkg.sv */
// Shared types and constants for the held-key repeat engine.
// No dependencies; every other design file but hkre_ram refers to it by scoped names.
package hkre_pkg;

    localparam int CODE_W     = 10;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W      = $clog2(MAX_RESULTS + 1);

    // request types
    localparam logic [1:0] REQ_KEY  = 2'd0;
    localparam logic [1:0] REQ_AXIS = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // stick axes
    localparam logic [1:0] AXIS_HORZ = 2'd0;
    localparam logic [1:0] AXIS_VERT = 2'd1;

    // stick direction codes
    localparam logic [1:0] DIR_NEUTRAL = 2'd0;
    localparam logic [1:0] DIR_POS     = 2'd1;
    localparam logic [1:0] DIR_NEG     = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UP       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN     = 3'd6;

    // register reset values (250 ms, 80 ms, 0.75 in Q0.15)
    localparam logic [15:0] DELAY_RST    = 16'd250;
    localparam logic [15:0] INTERVAL_RST = 16'd80;
    localparam logic [14:0] THRESH_RST   = 15'd24576;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CODE_W-1:0] key_code;
        logic              key_press;
        logic              key_up;
        logic              is_repeat;
        logic              is_gamepad;
        logic [2:0]        pad_slot;
        logic [1:0]        axis_kind;
        logic signed [15:0] axis_value;
    } t_item;

    typedef struct packed {
        logic [CODE_W-1:0] focus_key;
        logic              from_repeat;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [15:0]       repeat_delay;
        logic [15:0]       repeat_interval;
        logic [14:0]       axis_threshold;
        logic [CODE_W-1:0] dpad_left_code;
        logic [CODE_W-1:0] dpad_right_code;
        logic [CODE_W-1:0] dpad_up_code;
        logic [CODE_W-1:0] dpad_down_code;
    } t_cfg;

    // one lookup-and-update of the held table
    typedef struct packed {
        logic              vld;
        logic [CODE_W-1:0] code;
        logic              do_press;
        logic              do_rel;
    } t_key_op;

    typedef struct packed {
        logic    tick;
        t_key_op op0;
        t_key_op op1;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP_SCAN,
        ST_OP_APPLY,
        ST_TK_SCAN,
        ST_TK_ROUND,
        ST_TK_FLUSH
    } t_state;

endpackage

/* design/hkre_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module hkre_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 16
) (
    input  logic                                            i_clk,
    input  logic                                            i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]                                i_wdata,
    input  logic                                            i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_raddr,
    output logic [WIDTH-1:0]                                o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/hkre_cfg.sv */
// Configuration register file for the held-key repeat engine.
// Depends on hkre_pkg.
module hkre_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [hkre_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hkre_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_cfg_ready,
    output hkre_pkg::t_cfg                   o_cfg
);
    hkre_pkg::t_cfg r_cfg, n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                hkre_pkg::CFG_DELAY:    n_cfg.repeat_delay    = i_cfg_data;
                hkre_pkg::CFG_INTERVAL: n_cfg.repeat_interval = i_cfg_data;
                hkre_pkg::CFG_THRESH:   n_cfg.axis_threshold  = i_cfg_data[14:0];
                hkre_pkg::CFG_LEFT:  n_cfg.dpad_left_code  = i_cfg_data[hkre_pkg::CODE_W-1:0];
                hkre_pkg::CFG_RIGHT: n_cfg.dpad_right_code = i_cfg_data[hkre_pkg::CODE_W-1:0];
                hkre_pkg::CFG_UP:    n_cfg.dpad_up_code    = i_cfg_data[hkre_pkg::CODE_W-1:0];
                hkre_pkg::CFG_DOWN:  n_cfg.dpad_down_code  = i_cfg_data[hkre_pkg::CODE_W-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_delay    <= hkre_pkg::DELAY_RST;
            r_cfg.repeat_interval <= hkre_pkg::INTERVAL_RST;
            r_cfg.axis_threshold  <= hkre_pkg::THRESH_RST;
            r_cfg.dpad_left_code  <= '0;
            r_cfg.dpad_right_code <= '0;
            r_cfg.dpad_up_code    <= '0;
            r_cfg.dpad_down_code  <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

/* design/hkre_decode.sv */
// Request decoder: turns an item into table operations; holds stick directions.
// Depends on hkre_pkg.
module hkre_decode #(
    parameter int PAD_SLOTS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  hkre_pkg::t_item i_item,
    input  hkre_pkg::t_cfg  i_cfg,
    output hkre_pkg::t_job  o_job
);
    localparam int NS = 2 * PAD_SLOTS;
    localparam int SW = $clog2(NS);

    logic [NS-1:0][1:0] r_dir, n_dir;

    logic               w_axis_ok;
    logic [3:0]         w_pos;
    logic [SW-1:0]      w_sd_idx;
    logic signed [16:0] w_val, w_thr;
    logic [1:0]         w_cur, w_old;
    logic [hkre_pkg::CODE_W-1:0] w_neg_key, w_pos_key;
    logic               w_press;

    always_comb begin
        w_axis_ok = i_item.is_gamepad && (32'(i_item.pad_slot) < PAD_SLOTS)
                    && (i_item.axis_kind == hkre_pkg::AXIS_HORZ
                        || i_item.axis_kind == hkre_pkg::AXIS_VERT);
        w_pos     = {i_item.pad_slot, i_item.axis_kind[0]};
        w_sd_idx  = w_pos[SW-1:0];
        w_val     = {i_item.axis_value[15], i_item.axis_value};
        w_thr     = $signed({2'b00, i_cfg.axis_threshold});
        if (w_val < -w_thr) begin
            w_cur = hkre_pkg::DIR_NEG;
        end else if (w_val > w_thr) begin
            w_cur = hkre_pkg::DIR_POS;
        end else begin
            w_cur = hkre_pkg::DIR_NEUTRAL;
        end
        w_old = r_dir[w_sd_idx];
        if (i_item.axis_kind == hkre_pkg::AXIS_HORZ) begin
            w_neg_key = i_cfg.dpad_left_code;
            w_pos_key = i_cfg.dpad_right_code;
        end else begin
            w_neg_key = i_cfg.dpad_down_code;
            w_pos_key = i_cfg.dpad_up_code;
        end
        w_press = i_item.key_press && !i_item.is_repeat;
    end

    always_comb begin
        o_job = '0;
        case (i_item.req_type)
            hkre_pkg::REQ_KEY: begin
                o_job.op0.vld      = w_press || i_item.key_up;
                o_job.op0.code     = i_item.key_code;
                o_job.op0.do_press = w_press;
                o_job.op0.do_rel   = i_item.key_up;
            end
            hkre_pkg::REQ_AXIS: begin
                // release of the old direction first, then press of the new one
                if (w_axis_ok && (w_old != w_cur)) begin
                    o_job.op0.vld      = (w_old != hkre_pkg::DIR_NEUTRAL);
                    o_job.op0.code     = (w_old == hkre_pkg::DIR_POS) ? w_pos_key : w_neg_key;
                    o_job.op0.do_rel   = 1'b1;
                    o_job.op1.vld      = (w_cur != hkre_pkg::DIR_NEUTRAL);
                    o_job.op1.code     = (w_cur == hkre_pkg::DIR_POS) ? w_pos_key : w_neg_key;
                    o_job.op1.do_press = 1'b1;
                end
            end
            hkre_pkg::REQ_TICK: begin
                o_job.tick = 1'b1;
            end
            default: ;  // unused request type
        endcase
    end

    always_comb begin
        n_dir = r_dir;
        if (i_accept && (i_item.req_type == hkre_pkg::REQ_AXIS) && w_axis_ok) begin
            n_dir[w_sd_idx] = w_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= '0;
        end else begin
            r_dir <= n_dir;
        end
    end

endmodule

/* design/hkre_table.sv */
// Held-key table: entry RAM (code, trigger time), valid bits and the walk sequencer.
// Depends on hkre_pkg and hkre_ram.
module hkre_table #(
    parameter int HELD_KEYS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  hkre_pkg::t_job    i_job,
    input  hkre_pkg::t_cfg    i_cfg,
    output logic              o_busy,
    output logic              o_strobe,
    output hkre_pkg::t_result o_result
);
    localparam int IW = (HELD_KEYS > 1) ? $clog2(HELD_KEYS) : 1;
    localparam int CW = $clog2(HELD_KEYS + 1);
    localparam int TW = hkre_pkg::TIME_W;
    localparam int KW = hkre_pkg::CODE_W;
    localparam int EW = KW + TW;

    hkre_pkg::t_state r_state, n_state;

    // control
    logic [HELD_KEYS-1:0] r_valid, n_valid;
    logic [HELD_KEYS-1:0] r_done, n_done;
    logic [TW-1:0]        r_now, n_now;
    logic [CW-1:0]        r_addr, n_addr;
    logic                 r_rd_pend, n_rd_pend;
    logic                 r_op_sel, n_op_sel;
    logic                 r_hit, n_hit;
    logic                 r_free_found, n_free_found;
    logic                 r_best_found, n_best_found;
    logic                 r_pend_vld, n_pend_vld;
    logic [hkre_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_strobe, n_strobe;

    // payload
    hkre_pkg::t_job       r_job, n_job;
    logic [IW-1:0]        r_rd_idx, n_rd_idx;
    logic [IW-1:0]        r_hit_idx, n_hit_idx;
    logic [IW-1:0]        r_free_idx, n_free_idx;
    logic [IW-1:0]        r_best_idx, n_best_idx;
    logic [KW-1:0]        r_best_code, n_best_code;
    logic [KW-1:0]        r_pend_code, n_pend_code;
    hkre_pkg::t_result    r_result, n_result;

    // RAM port
    logic          w_we, w_re;
    logic [IW-1:0] w_waddr, w_raddr;
    logic [EW-1:0] w_wdata, w_rdata;
    logic [KW-1:0] w_rd_code;
    logic [TW-1:0] w_rd_due;

    logic             w_scan_issue, w_scan_end, w_rd_live;
    hkre_pkg::t_key_op w_op;

    hkre_ram #(
        .WIDTH (EW),
        .DEPTH (HELD_KEYS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_code    = w_rdata[EW-1:TW];
    assign w_rd_due     = w_rdata[TW-1:0];
    assign w_scan_issue = (r_addr != CW'(HELD_KEYS));
    assign w_scan_end   = !w_scan_issue && !r_rd_pend;
    assign w_rd_live    = r_rd_pend && r_valid[r_rd_idx];
    assign w_op         = r_op_sel ? r_job.op1 : r_job.op0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hkre_pkg::ST_IDLE: begin
                if (i_accept) begin
                    if (i_job.tick) begin
                        n_state = hkre_pkg::ST_TK_SCAN;
                    end else if (i_job.op0.vld || i_job.op1.vld) begin
                        n_state = hkre_pkg::ST_OP_SCAN;
                    end
                end
            end
            hkre_pkg::ST_OP_SCAN: begin
                if (w_scan_end) n_state = hkre_pkg::ST_OP_APPLY;
            end
            hkre_pkg::ST_OP_APPLY: begin
                n_state = (!r_op_sel && r_job.op1.vld) ? hkre_pkg::ST_OP_SCAN
                                                       : hkre_pkg::ST_IDLE;
            end
            hkre_pkg::ST_TK_SCAN: begin
                if (w_scan_end) n_state = hkre_pkg::ST_TK_ROUND;
            end
            hkre_pkg::ST_TK_ROUND: begin
                if (!r_best_found) begin
                    n_state = hkre_pkg::ST_IDLE;
                end else if (r_cnt == hkre_pkg::CNT_W'(hkre_pkg::MAX_RESULTS - 1)) begin
                    n_state = hkre_pkg::ST_TK_FLUSH;
                end else begin
                    n_state = hkre_pkg::ST_TK_SCAN;
                end
            end
            hkre_pkg::ST_TK_FLUSH: n_state = hkre_pkg::ST_IDLE;
            default:               n_state = hkre_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_valid      = r_valid;
        n_done       = r_done;
        n_now        = r_now;
        n_addr       = r_addr;
        n_rd_pend    = 1'b0;
        n_op_sel     = r_op_sel;
        n_hit        = r_hit;
        n_free_found = r_free_found;
        n_best_found = r_best_found;
        n_pend_vld   = r_pend_vld;
        n_cnt        = r_cnt;
        n_strobe     = 1'b0;
        n_job        = r_job;
        n_rd_idx     = r_rd_idx;
        n_hit_idx    = r_hit_idx;
        n_free_idx   = r_free_idx;
        n_best_idx   = r_best_idx;
        n_best_code  = r_best_code;
        n_pend_code  = r_pend_code;
        n_result     = r_result;
        w_we         = 1'b0;
        w_waddr      = r_free_idx;
        w_wdata      = {w_op.code, r_now + TW'(i_cfg.repeat_delay)};
        w_re         = 1'b0;
        w_raddr      = r_addr[IW-1:0];

        case (r_state)
            hkre_pkg::ST_IDLE: begin
                if (i_accept) begin
                    n_job        = i_job;
                    n_op_sel     = !i_job.op0.vld;
                    n_addr       = '0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    n_best_found = 1'b0;
                    if (i_job.tick) begin
                        n_now      = r_now + TW'(1);
                        n_done     = '0;
                        n_cnt      = '0;
                        n_pend_vld = 1'b0;
                    end
                end
            end

            hkre_pkg::ST_OP_SCAN, hkre_pkg::ST_TK_SCAN: begin
                if (w_scan_issue) begin
                    w_re      = 1'b1;
                    n_addr    = r_addr + CW'(1);
                    n_rd_pend = 1'b1;
                    n_rd_idx  = r_addr[IW-1:0];
                end
                if (r_state == hkre_pkg::ST_OP_SCAN) begin
                    if (w_rd_live && (w_rd_code == w_op.code)) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_rd_idx;
                    end
                    // lowest free entry
                    if (r_rd_pend && !r_valid[r_rd_idx] && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_rd_idx;
                    end
                end else begin
                    if (w_rd_live && !r_done[r_rd_idx] && (w_rd_due < r_now)
                        && (!r_best_found || (w_rd_code < r_best_code))) begin
                        n_best_found = 1'b1;
                        n_best_idx   = r_rd_idx;
                        n_best_code  = w_rd_code;
                    end
                end
            end

            hkre_pkg::ST_OP_APPLY: begin
                if (w_op.do_press) begin
                    // a held code swallows the whole event
                    if (!r_hit) begin
                        n_strobe             = 1'b1;
                        n_result.focus_key   = w_op.code;
                        n_result.from_repeat = 1'b0;
                        n_result.last        = 1'b1;
                        if (r_free_found) begin
                            w_we                = 1'b1;
                            n_valid[r_free_idx] = !w_op.do_rel;
                        end
                    end
                end else if (w_op.do_rel && r_hit) begin
                    n_valid[r_hit_idx] = 1'b0;
                end
                n_op_sel     = 1'b1;
                n_addr       = '0;
                n_hit        = 1'b0;
                n_free_found = 1'b0;
            end

            hkre_pkg::ST_TK_ROUND: begin
                // results go out one round late so the final one can carry last
                if (r_best_found) begin
                    w_we                = 1'b1;
                    w_waddr             = r_best_idx;
                    w_wdata             = {r_best_code, r_now + TW'(i_cfg.repeat_interval)};
                    n_done[r_best_idx]  = 1'b1;
                    n_strobe            = r_pend_vld;
                    n_result.focus_key  = r_pend_code;
                    n_result.from_repeat = 1'b1;
                    n_result.last       = 1'b0;
                    n_pend_code         = r_best_code;
                    n_pend_vld          = 1'b1;
                    n_cnt               = r_cnt + hkre_pkg::CNT_W'(1);
                end else begin
                    n_strobe             = r_pend_vld;
                    n_result.focus_key   = r_pend_code;
                    n_result.from_repeat = 1'b1;
                    n_result.last        = 1'b1;
                end
                n_addr       = '0;
                n_best_found = 1'b0;
            end

            hkre_pkg::ST_TK_FLUSH: begin
                n_strobe             = 1'b1;
                n_result.focus_key   = r_pend_code;
                n_result.from_repeat = 1'b1;
                n_result.last        = 1'b1;
            end

            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hkre_pkg::ST_IDLE;
            r_valid      <= '0;
            r_done       <= '0;
            r_now        <= '0;
            r_addr       <= '0;
            r_rd_pend    <= 1'b0;
            r_op_sel     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_best_found <= 1'b0;
            r_pend_vld   <= 1'b0;
            r_cnt        <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_done       <= n_done;
            r_now        <= n_now;
            r_addr       <= n_addr;
            r_rd_pend    <= n_rd_pend;
            r_op_sel     <= n_op_sel;
            r_hit        <= n_hit;
            r_free_found <= n_free_found;
            r_best_found <= n_best_found;
            r_pend_vld   <= n_pend_vld;
            r_cnt        <= n_cnt;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job       <= n_job;
        r_rd_idx    <= n_rd_idx;
        r_hit_idx   <= n_hit_idx;
        r_free_idx  <= n_free_idx;
        r_best_idx  <= n_best_idx;
        r_best_code <= n_best_code;
        r_pend_code <= n_pend_code;
        r_result    <= n_result;
    end

    assign o_busy   = (r_state != hkre_pkg::ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

/* design/held_key_repeat_engine.sv */
// A key event or stick sample gives its result, if any, after a walk of the table;
//   a stick sample that both releases and presses walks the table twice.
// A tick firing R entries holds busy for one full walk through the single RAM read port
//   per fired entry plus a closing empty walk; at 16 results a flush state replaces the
//   empty walk. Results cannot stall.
// Reset (synchronous, active low): table empty, time zero, sticks neutral, registers default.
module held_key_repeat_engine #(
    parameter int HELD_KEYS = 16,
    parameter int PAD_SLOTS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // item channel
    input  logic                             start,
    output logic                             busy,
    input  hkre_pkg::t_item                  i_item,
    // results
    output logic                             o_strobe,
    output hkre_pkg::t_result                o_result,
    // register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hkre_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hkre_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    // An item is taken whenever the table sequencer is idle.
    logic           w_accept;
    logic           w_busy;
    hkre_pkg::t_cfg w_cfg;
    hkre_pkg::t_job w_job;

    assign w_accept = start && !w_busy;
    assign busy     = w_busy;

    // Register file; the user issues writes only while idle (unenforced); no shadowing.
    hkre_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    // Decoder: key events map to one table operation; a stick sample whose direction
    // changes maps to a release of its old D-pad code and a press of the new one,
    // each unless neutral. Per-stick direction is kept here, updated on the accept edge.
    hkre_decode #(
        .PAD_SLOTS (PAD_SLOTS)
    ) u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .i_cfg    (w_cfg),
        .o_job    (w_job)
    );

    // Held table: codes and trigger times live in one RAM. Every operation walks
    // all entries (read, compare), then does at most one write back, so reads and
    // the write to an entry never overlap. Ticks pick the lowest due code per
    // walk and reschedule it; output runs one walk behind to mark the last item.
    hkre_table #(
        .HELD_KEYS (HELD_KEYS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_job    (w_job),
        .i_cfg    (w_cfg),
        .o_busy   (w_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

/* design/hkre_checker.sv */
// Port-level checks for the held-key repeat engine, bound to the top level.
// Depends on hkre_pkg and held_key_repeat_engine.
module hkre_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input hkre_pkg::t_result o_result
);
    // a key-press result is always the only one of its item
    a_key_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.from_repeat |-> o_result.last)
        else $error("key result without last");

    // the table walk takes time: nothing comes out right after an accept
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_strobe)
        else $error("result in cycle after accept");

    // more results pending means the block still reports busy
    a_busy_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy)
        else $error("idle while results pending");

    // nothing follows the last item of an input straight away
    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |=> !o_strobe)
        else $error("result after last");

endmodule

bind held_key_repeat_engine hkre_checker u_hkre_checker (.*);

/* bench/tb_held_key_repeat_engine.sv */
`timescale 1ns / 1ps
// Self-checking bench for held_key_repeat_engine: queued command items, in-order result check.
// Depends on hkre_pkg for the item, result and register types and on the engine RTL.
module tb_held_key_repeat_engine;

    localparam int HELD   = 16;       // table depth of the instance
    localparam int SLOTS  = 8;        // gamepad slots of the instance
    localparam int LIMIT  = 600000;   // cycle budget for the whole run
    localparam int SETTLE = 400;      // quiet cycles before a register write and at the end
    localparam int SHOWN  = 10;       // mismatches printed in full
    localparam int ITEM_W = $bits(hkre_pkg::t_item);

    localparam logic [1:0]                     REQ_SPARE = 2'd3;  // unused request code
    localparam logic [hkre_pkg::CFG_IDX_W-1:0] CFG_NONE  = 3'd7;  // index with no register

    logic                            i_clk;
    logic                            i_rst_n     = 1'b0;
    logic                            start       = 1'b0;
    logic                            busy;
    hkre_pkg::t_item                 i_item      = '0;
    logic                            o_strobe;
    hkre_pkg::t_result               o_result;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [hkre_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [hkre_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // shadow of the engine: registers, held table, time, stick directions
    hkre_pkg::t_cfg              cfg_now;
    logic                        held_vld   [HELD];
    logic [hkre_pkg::CODE_W-1:0] held_key   [HELD];
    logic [hkre_pkg::TIME_W-1:0] held_due   [HELD];
    logic [hkre_pkg::TIME_W-1:0] now_ticks;
    logic [1:0]                  stick_state[2*SLOTS];

    hkre_pkg::t_result new_res[$];      // results of the item being predicted
    hkre_pkg::t_result focus_exp_q[$];  // focus moves still to come out of the engine
    hkre_pkg::t_item   cmd_q[$];        // items waiting for the driver

    int fail_cnt  = 0;
    int cycle_cnt = 0;
    int gap_left  = 0;
    int calm_left = 0;

    held_key_repeat_engine #(
        .HELD_KEYS(HELD),
        .PAD_SLOTS(SLOTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- shadow model

    function automatic void reset_shadow();
        cfg_now                 = '0;
        cfg_now.repeat_delay    = hkre_pkg::DELAY_RST;
        cfg_now.repeat_interval = hkre_pkg::INTERVAL_RST;
        cfg_now.axis_threshold  = hkre_pkg::THRESH_RST;
        for (int i = 0; i < HELD; i++) begin
            held_vld[i] = 1'b0;
            held_key[i] = '0;
            held_due[i] = '0;
        end
        for (int i = 0; i < 2*SLOTS; i++) stick_state[i] = hkre_pkg::DIR_NEUTRAL;
        now_ticks = '0;
    endfunction

    function automatic void apply_cfg(logic [hkre_pkg::CFG_IDX_W-1:0] idx,
                                      logic [hkre_pkg::CFG_DATA_W-1:0] d);
        case (idx)
            hkre_pkg::CFG_DELAY:    cfg_now.repeat_delay    = d;
            hkre_pkg::CFG_INTERVAL: cfg_now.repeat_interval = d;
            hkre_pkg::CFG_THRESH:   cfg_now.axis_threshold  = d[14:0];
            hkre_pkg::CFG_LEFT:     cfg_now.dpad_left_code  = d[hkre_pkg::CODE_W-1:0];
            hkre_pkg::CFG_RIGHT:    cfg_now.dpad_right_code = d[hkre_pkg::CODE_W-1:0];
            hkre_pkg::CFG_UP:       cfg_now.dpad_up_code    = d[hkre_pkg::CODE_W-1:0];
            hkre_pkg::CFG_DOWN:     cfg_now.dpad_down_code  = d[hkre_pkg::CODE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int find_held(logic [hkre_pkg::CODE_W-1:0] code);
        for (int i = 0; i < HELD; i++)
            if (held_vld[i] && held_key[i] == code) return i;
        return -1;
    endfunction

    function automatic void add_res(hkre_pkg::t_result r);
        new_res = {new_res, r};
    endfunction

    function automatic void add_cmd(hkre_pkg::t_item it);
        cmd_q = {cmd_q, it};
    endfunction

    // fresh press: store if room, emit regardless; a held code makes it a no-op
    function automatic bit take_press(logic [hkre_pkg::CODE_W-1:0] code);
        hkre_pkg::t_result r;
        if (find_held(code) >= 0) return 1'b0;
        for (int i = 0; i < HELD; i++) begin
            if (!held_vld[i]) begin
                held_vld[i] = 1'b1;
                held_key[i] = code;
                held_due[i] = now_ticks + hkre_pkg::TIME_W'(cfg_now.repeat_delay);
                break;
            end
        end
        r.focus_key   = code;
        r.from_repeat = 1'b0;
        r.last        = 1'b0;
        add_res(r);
        return 1'b1;
    endfunction

    function automatic void drop_key(logic [hkre_pkg::CODE_W-1:0] code);
        int i;
        i = find_held(code);
        if (i >= 0) held_vld[i] = 1'b0;
    endfunction

    // advance time, then fire every overdue entry once, lowest code first
    function automatic void run_tick();
        logic              fired[HELD];
        hkre_pkg::t_result r;
        int                best;
        for (int i = 0; i < HELD; i++) fired[i] = 1'b0;
        now_ticks = now_ticks + 1;
        for (int k = 0; k < hkre_pkg::MAX_RESULTS; k++) begin
            best = -1;
            for (int i = 0; i < HELD; i++) begin
                if (held_vld[i] && !fired[i] && held_due[i] < now_ticks) begin
                    if (best < 0) best = i;
                    else if (held_key[i] < held_key[best]) best = i;
                end
            end
            if (best < 0) break;
            fired[best]   = 1'b1;
            r.focus_key   = held_key[best];
            r.from_repeat = 1'b1;
            r.last        = 1'b0;
            add_res(r);
            held_due[best] = now_ticks + hkre_pkg::TIME_W'(cfg_now.repeat_interval);
        end
    endfunction

    // stick sample: a change of direction releases the old D-pad key, presses the new one
    function automatic void run_axis(hkre_pkg::t_item it);
        int                          v;
        int                          thr;
        int                          idx;
        logic [1:0]                  cur;
        logic [1:0]                  old;
        logic [hkre_pkg::CODE_W-1:0] neg_key;
        logic [hkre_pkg::CODE_W-1:0] pos_key;
        if (!it.is_gamepad || int'(it.pad_slot) >= SLOTS) return;
        if (it.axis_kind != hkre_pkg::AXIS_HORZ && it.axis_kind != hkre_pkg::AXIS_VERT) return;
        v   = int'($signed(it.axis_value));
        thr = int'(cfg_now.axis_threshold);
        cur = hkre_pkg::DIR_NEUTRAL;
        if (v < -thr) cur = hkre_pkg::DIR_NEG;
        else if (v > thr) cur = hkre_pkg::DIR_POS;
        if (it.axis_kind == hkre_pkg::AXIS_HORZ) begin
            neg_key = cfg_now.dpad_left_code;
            pos_key = cfg_now.dpad_right_code;
        end else begin
            neg_key = cfg_now.dpad_down_code;
            pos_key = cfg_now.dpad_up_code;
        end
        idx = int'(it.pad_slot) * 2 + int'(it.axis_kind);
        old = stick_state[idx];
        stick_state[idx] = cur;
        if (old == cur) return;
        if (old == hkre_pkg::DIR_POS) drop_key(pos_key);
        else if (old == hkre_pkg::DIR_NEG) drop_key(neg_key);
        if (cur == hkre_pkg::DIR_POS) void'(take_press(pos_key));
        else if (cur == hkre_pkg::DIR_NEG) void'(take_press(neg_key));
    endfunction

    // works out the focus moves of one accepted item and queues them
    function automatic void predict_focus(hkre_pkg::t_item it);
        bit                go_on;
        hkre_pkg::t_result r;
        new_res.delete();
        case (it.req_type)
            hkre_pkg::REQ_KEY: begin
                go_on = 1'b1;
                if (it.key_press && !it.is_repeat) go_on = take_press(it.key_code);
                // a press of a held code swallows the release flag too
                if (go_on && it.key_up) drop_key(it.key_code);
            end
            hkre_pkg::REQ_AXIS: run_axis(it);
            hkre_pkg::REQ_TICK: run_tick();
            default: ;
        endcase
        if (new_res.size() > 0) begin
            r = new_res[$];
            r.last = 1'b1;
            new_res[new_res.size()-1] = r;
        end
        focus_exp_q = {focus_exp_q, new_res};
    endfunction

    // ---------------------------------------------------------------- item builders

    function automatic hkre_pkg::t_item mk_key(logic [hkre_pkg::CODE_W-1:0] code, logic dn,
                                               logic up, logic rep);
        hkre_pkg::t_item it;
        it           = '0;
        it.req_type  = hkre_pkg::REQ_KEY;
        it.key_code  = code;
        it.key_press = dn;
        it.key_up    = up;
        it.is_repeat = rep;
        return it;
    endfunction

    function automatic hkre_pkg::t_item mk_axis(logic gp, logic [2:0] slot, logic [1:0] kind,
                                                logic signed [15:0] val);
        hkre_pkg::t_item it;
        it            = '0;
        it.req_type   = hkre_pkg::REQ_AXIS;
        it.is_gamepad = gp;
        it.pad_slot   = slot;
        it.axis_kind  = kind;
        it.axis_value = val;
        return it;
    endfunction

    function automatic hkre_pkg::t_item mk_tick();
        hkre_pkg::t_item it;
        it          = '0;
        it.req_type = hkre_pkg::REQ_TICK;
        return it;
    endfunction

    // Random item: every field starts as noise, then the request is shaped. Key codes come
    // mostly from a small pool plus the D-pad codes so presses, releases and a full table meet.
    function automatic hkre_pkg::t_item rand_item();
        logic [ITEM_W-1:0] raw;
        hkre_pkg::t_item   it;
        int                sel;
        int                mode;
        int                mag;
        int                k;
        raw = ITEM_W'({$urandom, $urandom});
        it  = raw;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            it.req_type = hkre_pkg::REQ_KEY;
            if ($urandom_range(0, 99) < 85) begin
                k = $urandom_range(0, 23);
                case (k)
                    20:      it.key_code = cfg_now.dpad_left_code;
                    21:      it.key_code = cfg_now.dpad_right_code;
                    22:      it.key_code = cfg_now.dpad_up_code;
                    23:      it.key_code = cfg_now.dpad_down_code;
                    default: it.key_code = hkre_pkg::CODE_W'(k * 37 + 11);
                endcase
            end
            mode = $urandom_range(0, 9);
            if (mode < 5) begin
                it.key_press = 1'b1;
                it.key_up    = 1'b0;
            end else if (mode < 8) begin
                it.key_press = 1'b0;
                it.key_up    = 1'b1;
            end else if (mode == 8) begin
                it.key_press = 1'b1;
                it.key_up    = 1'b1;
            end
            it.is_repeat = ($urandom_range(0, 9) == 0);
        end else if (sel < 70) begin
            it.req_type = hkre_pkg::REQ_TICK;
        end else if (sel < 92) begin
            it.req_type   = hkre_pkg::REQ_AXIS;
            it.is_gamepad = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 9) != 0) it.axis_kind = 2'($urandom_range(0, 1));
            mag = int'(cfg_now.axis_threshold) + int'($urandom_range(0, 300));
            case ($urandom_range(0, 3))
                0: ;  // full-range noise
                1: it.axis_value = 16'((mag > 32767) ? 32767 : mag);
                2: it.axis_value = 16'(-((mag > 32768) ? 32768 : mag));
                default: it.axis_value = 16'($urandom_range(0, 2) - 1);
            endcase
        end else begin
            if ($urandom_range(0, 1) == 0) begin
                it.req_type = REQ_SPARE;
            end else begin
                it.req_type   = hkre_pkg::REQ_AXIS;
                it.is_gamepad = 1'b0;
            end
        end
        return it;
    endfunction

    // ---------------------------------------------------------------- register writes

    // call just after a rising edge; leaves valid high for a following write
    task automatic cfg_write(logic [hkre_pkg::CFG_IDX_W-1:0] idx,
                             logic [hkre_pkg::CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_cfg(idx, d);
    endtask

    task automatic set_regs(logic [15:0] dly, logic [15:0] ivl, logic [15:0] thr,
                            logic [15:0] lc, logic [15:0] rc, logic [15:0] uc,
                            logic [15:0] dc);
        @(posedge i_clk);
        cfg_write(hkre_pkg::CFG_DELAY,    dly);
        cfg_write(hkre_pkg::CFG_INTERVAL, ivl);
        cfg_write(hkre_pkg::CFG_THRESH,   thr);
        cfg_write(hkre_pkg::CFG_LEFT,     lc);
        cfg_write(hkre_pkg::CFG_RIGHT,    rc);
        cfg_write(hkre_pkg::CFG_UP,       uc);
        cfg_write(hkre_pkg::CFG_DOWN,     dc);
        i_cfg_valid <= 1'b0;
    endtask

    // wait until every item is in and every focus move out, then let the engine settle
    task automatic drain();
        do @(negedge i_clk); while (cmd_q.size() != 0 || start || focus_exp_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic fill_random(int n);
        repeat (n) add_cmd(rand_item());
    endtask

    // ---------------------------------------------------------------- driver

    // Loads the next item once the gap runs out; start stays high until busy drops.
    always @(posedge i_clk) begin
        logic            nxt_start;
        bit              load;
        hkre_pkg::t_item nxt_item;
        int              pick;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            nxt_start = start;
            load      = 1'b0;
            nxt_item  = i_item;
            if (start && !busy) begin
                predict_focus(i_item);
                nxt_start = 1'b0;
                if (calm_left > 0) begin
                    calm_left--;
                    gap_left = 0;
                end else begin
                    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(8, 20);
                    pick = $urandom_range(0, 9);
                    if (pick < 6) gap_left = 0;
                    else if (pick < 9) gap_left = $urandom_range(1, 4);
                    else gap_left = $urandom_range(20, 400);
                end
            end
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_q.size() > 0) begin
                    nxt_item  = cmd_q.pop_front();
                    load      = 1'b1;
                    nxt_start = 1'b1;
                end
            end
            start <= nxt_start;
            if (load) i_item <= nxt_item;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        hkre_pkg::t_result want;
        if (i_rst_n && o_strobe) begin
            if (focus_exp_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= SHOWN)
                    $display("unexpected result: key %0d rep %0b last %0b",
                             o_result.focus_key, o_result.from_repeat, o_result.last);
            end else begin
                want = focus_exp_q.pop_front();
                if (o_result.focus_key   !== want.focus_key   ||
                    o_result.from_repeat !== want.from_repeat ||
                    o_result.last        !== want.last) begin
                    fail_cnt++;
                    if (fail_cnt <= SHOWN)
                        $display("mismatch: expected %0d %0b %0b, got %0d %0b %0b",
                                 want.focus_key, want.from_repeat, want.last,
                                 o_result.focus_key, o_result.from_repeat, o_result.last);
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        reset_shadow();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: D-pad codes all zero, long delay so nothing repeats yet.
        add_cmd(mk_key(10'd0,    1'b1, 1'b0, 1'b0));   // lowest code
        add_cmd(mk_key(10'd1023, 1'b1, 1'b0, 1'b0));   // highest code
        add_cmd(mk_key(10'd0,    1'b1, 1'b1, 1'b0));   // held: release ignored too
        add_cmd(mk_key(10'd5,    1'b1, 1'b1, 1'b0));   // press and release together
        add_cmd(mk_key(10'd7,    1'b1, 1'b1, 1'b1));   // source repeat, release acts
        add_cmd(mk_key(10'd1023, 1'b1, 1'b0, 1'b1));   // source repeat of a held key
        add_cmd(mk_key(10'd1023, 1'b0, 1'b1, 1'b0));   // plain release
        add_cmd(mk_key(10'd77,   1'b0, 1'b1, 1'b0));   // release of a code not held
        add_cmd(mk_key(10'd88,   1'b0, 1'b0, 1'b0));   // no flags at all
        add_cmd(mk_axis(1'b1, 3'd0, hkre_pkg::AXIS_HORZ, 16'sd32767));  // press of held 0
        add_cmd(mk_axis(1'b1, 3'd7, hkre_pkg::AXIS_VERT, 16'sh8000));
        add_cmd(mk_axis(1'b1, 3'd0, hkre_pkg::AXIS_HORZ, 16'sh8000));   // release, press
        add_cmd(mk_axis(1'b0, 3'd1, hkre_pkg::AXIS_HORZ, 16'sd32767));  // not a gamepad
        add_cmd(mk_axis(1'b1, 3'd2, 2'd2, 16'sd32767));                 // other axis
        add_cmd(mk_axis(1'b1, 3'd2, 2'd3, 16'sh8000));                  // spare axis code
        add_cmd(mk_axis(1'b1, 3'd0, hkre_pkg::AXIS_HORZ, 16'sd24576));  // on threshold
        add_cmd(mk_axis(1'b1, 3'd0, hkre_pkg::AXIS_HORZ, 16'sd24577));  // just past it
        add_cmd(mk_key(10'd300, 1'b0, 1'b0, 1'b0) | hkre_pkg::t_item'({REQ_SPARE, 35'd0}));
        add_cmd(mk_tick());
        drain();

        // Shortest timings, zero threshold, distinct D-pad codes; a write to no register.
        set_regs(16'd1, 16'd1, 16'd0, 16'd1023, 16'd1, 16'd2, 16'd3);
        @(posedge i_clk);
        cfg_write(CFG_NONE, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        add_cmd(mk_key(10'd20, 1'b1, 1'b0, 1'b0));
        add_cmd(mk_key(10'd10, 1'b1, 1'b0, 1'b0));
        add_cmd(mk_axis(1'b1, 3'd3, hkre_pkg::AXIS_VERT, 16'sd1));  // up code, zero threshold
        repeat (4) add_cmd(mk_tick());                           // repeats fire in code order
        fill_random(26);
        drain();

        // Longest timings, top threshold.
        set_regs(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'd0, 16'd1022, 16'd512, 16'd511);
        fill_random(26);
        drain();

        // Mid settings; stray upper data bits must be masked off.
        set_regs(16'd2, 16'd3, {1'b1, 15'd16384}, 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
        fill_random(26);
        drain();

        // Random short timings and threshold.
        set_regs(16'($urandom_range(1, 8)), 16'($urandom_range(1, 5)),
                 16'($urandom_range(0, 32767)), 16'($urandom_range(0, 1023)),
                 16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
                 16'($urandom_range(0, 1023)));
        fill_random(26);
        drain();

        if (fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
design/hkre_pkg.sv
design/hkre_ram.sv
design/hkre_cfg.sv
design/hkre_decode.sv
design/hkre_table.sv
design/held_key_repeat_engine.sv
design/hkre_checker.sv
bench/tb_held_key_repeat_engine.sv
